// File: rtl/core/hav_pkg.sv
// Shared types, constants and the arctangent table for the haversine pipeline.
// No dependencies; imported by hav_cordic_cell, hav_sqrt_cell and the top level.
`default_nettype none

package hav_pkg;

  // CORDIC datapath width (x, y, z), signed
  localparam int CW = 34;
  // square-root cell width (remainder and partial root)
  localparam int SQ_W = 62;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;
  // round(pi/180 * 2^37)
  localparam logic [31:0] DEG_SCALE = 32'((((PI_Q62 >> 24) / 64'd180) + 64'd1) >> 1);
  localparam logic [63:0] CORDIC_GAIN_Q30 = 64'd652032874;
  localparam logic [29:0] DIST_MAX = 30'h3FFFFFFF;
  localparam logic [22:0] RADIUS_RESET = 23'd6371008;

  localparam logic [31:0] ATAN_HEAD [11] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149, 32'd1048575
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] r;
  } sqrt_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] res;
    if (i < 11) begin
      res = ATAN_HEAD[i[3:0]];
    end else if (i < 30) begin
      res = (32'd1 << (30 - i)) - 32'd1;
    end else begin
      res = '0;
    end
    return res;
  endfunction

  // clamp to [0, 1.0] in Q30
  function automatic logic [30:0] clamp_unit(input logic signed [CW-1:0] v);
    logic [30:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(CW'(ONE_Q30))) begin
      res = 31'(ONE_Q30);
    end else begin
      res = 31'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/hav_reduce_cell.sv
// One compare-subtract step of a modular angle reduction chain.
// Depends on nothing but its parameters.
`default_nettype none

module hav_reduce_cell #(
  parameter int W = 34,
  parameter logic [63:0] STEP = 64'd1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [63:0] x64;
  logic [63:0] diff;

  assign x64  = 64'(din);
  assign diff = x64 - STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= (x64 >= STEP) ? W'(diff) : din;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hav_cordic_cell.sv
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
// Depends on hav_pkg (cordic_t, atan_q30).
`default_nettype none

module hav_cordic_cell #(
  parameter int STAGE  = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic             clk,
  input  logic             en,
  input  hav_pkg::cordic_t din,
  output hav_pkg::cordic_t dout
);

  import hav_pkg::*;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] at;
  logic                 ccw;

  assign xs  = $signed(din.x) >>> STAGE;
  assign ys  = $signed(din.y) >>> STAGE;
  assign at  = $signed(CW'(atan_q30(STAGE)));
  // vectoring drives y toward zero, rotation drives z toward zero
  assign ccw = VECTOR ? !($signed(din.y) > 0) : ($signed(din.z) >= 0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (ccw) begin
        dout.x <= din.x - ys;
        dout.y <= din.y + xs;
        dout.z <= din.z - at;
      end else begin
        dout.x <= din.x + ys;
        dout.y <= din.y - xs;
        dout.z <= din.z + at;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hav_sqrt_cell.sv
// One digit step of a restoring floor square root (one root bit per cell).
// Depends on hav_pkg (sqrt_t, SQ_W).
`default_nettype none

module hav_sqrt_cell #(
  parameter int SHIFT = 0
) (
  input  logic           clk,
  input  logic           en,
  input  hav_pkg::sqrt_t din,
  output hav_pkg::sqrt_t dout
);

  import hav_pkg::*;

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << SHIFT;

  logic [SQ_W-1:0] trial;

  assign trial = din.r + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (din.v >= trial) begin
        dout.v <= din.v - trial;
        dout.r <= (din.r >> 1) + BIT;
      end else begin
        dout.v <= din.v;
        dout.r <= din.r >> 1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/great_circle_distance_haversine_top.sv
// Haversine great-circle distance, fully pipelined.
// Angle reduction uses RED_N compare-subtract cells per lane, where
// RED_N = max(54 - ANGLE_FRAC_BITS, 33) - 31.
// Throughput: one beat per cycle; the pipeline freezes only while the result is stalled.
// Reset (rst, synchronous): clears the valid chain and the input skid; radius to 6371008.
// Depends on hav_pkg, hav_reduce_cell, hav_cordic_cell, hav_sqrt_cell.
`default_nettype none

module great_circle_distance_haversine_top #(
  parameter int ANGLE_FRAC_BITS = 20,
  parameter int CORDIC_STAGES   = 24
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [27:0] first_latitude,
  input  logic signed [28:0] first_longitude,
  input  logic signed [27:0] second_latitude,
  input  logic signed [28:0] second_longitude,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [29:0]        distance_q4,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import hav_pkg::*;

  // Radians after degree conversion are reduced by a chain of compare-subtract
  // cells; RED_W covers the widest lane (longitude difference, half angle).
  localparam int RED_W = ((54 - ANGLE_FRAC_BITS) > 33) ? (54 - ANGLE_FRAC_BITS) : 33;
  localparam int RED_N = RED_W - 31;
  localparam int SQ_N  = 31;
  localparam int LAT   = 42 + RED_N + 2 * CORDIC_STAGES;

  localparam logic REG_RADIUS = 1'b0;

  //--------------------------------------------------------------------------
  // Register port: one register, earth radius. Index is paddr[2].
  //--------------------------------------------------------------------------
  logic [22:0] radius;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RADIUS) ? {9'd0, radius} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_RADIUS) begin
      radius <= pwdata[22:0];
    end
  end

  //--------------------------------------------------------------------------
  // Flow control. Every stage advances together; adv drops only when the
  // output register holds a beat the consumer stalls. A one-entry skid on the
  // input keeps in_stall a plain register.
  //--------------------------------------------------------------------------
  logic           adv;
  logic           in_acc;
  logic           skid_full;
  logic [LAT-1:0] vld;
  logic           src_valid;

  logic signed [27:0] skid_lat1, skid_lat2;
  logic signed [28:0] skid_lon1, skid_lon2;
  logic signed [27:0] src_lat1, src_lat2;
  logic signed [28:0] src_lon1, src_lon2;

  assign adv       = !(vld[LAT-1] && out_stall);
  assign in_stall  = skid_full;
  assign in_acc    = in_valid && !skid_full;
  assign src_valid = skid_full || in_valid;
  assign out_valid = vld[LAT-1];

  assign src_lat1 = skid_full ? skid_lat1 : first_latitude;
  assign src_lon1 = skid_full ? skid_lon1 : first_longitude;
  assign src_lat2 = skid_full ? skid_lat2 : second_latitude;
  assign src_lon2 = skid_full ? skid_lon2 : second_longitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
      vld       <= '0;
    end else if (adv) begin
      vld       <= {vld[LAT-2:0], src_valid};
      skid_full <= 1'b0;
    end else if (in_acc) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_acc) begin
      skid_lat1 <= first_latitude;
      skid_lon1 <= first_longitude;
      skid_lat2 <= second_latitude;
      skid_lon2 <= second_longitude;
    end
  end

  //--------------------------------------------------------------------------
  // Four angle lanes: 0 = lat difference, 1 = lon difference (half angles,
  // reduced mod pi), 2 = lat1, 3 = lat2 (full angles, reduced mod 2*pi).
  // Only magnitudes matter: sin^2 and cos are both even.
  //--------------------------------------------------------------------------
  function automatic logic [29:0] abs30(input logic signed [29:0] v);
    return v[29] ? 30'(-v) : 30'(v);
  endfunction

  logic [29:0] mag_src [4];

  always_comb begin
    mag_src[0] = abs30(30'(src_lat2) - 30'(src_lat1));
    mag_src[1] = abs30(30'(src_lon2) - 30'(src_lon1));
    mag_src[2] = abs30(30'(src_lat1));
    mag_src[3] = abs30(30'(src_lat2));
  end

  logic [29:0]      mag   [4];
  logic [61:0]      prod  [4];
  logic [RED_W-1:0] red   [4][RED_N+1];
  logic [32:0]      theta [4];
  logic             fold_neg [4];
  cordic_t          rot   [4][CORDIC_STAGES+1];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam int SH = ANGLE_FRAC_BITS + ((l < 2) ? 8 : 7);
    localparam logic [63:0] MODV = (l < 2) ? PI_Q30 : TWO_PI_Q30;

    logic [62:0] rsum;
    logic [63:0] hv;
    logic [63:0] wrap;
    logic [63:0] fold;
    logic        fneg;

    // degrees to Q30 radians, round half up
    assign rsum = 63'(prod[l]) + (63'(1) << (SH - 1));

    always_ff @(posedge clk) begin
      if (adv) begin
        mag[l]    <= mag_src[l];
        prod[l]   <= 62'(mag[l]) * 62'(DEG_SCALE);
        red[l][0] <= RED_W'(rsum >> SH);
      end
    end

    for (genvar j = 0; j < RED_N; j++) begin : g_red
      hav_reduce_cell #(
        .W    (RED_W),
        .STEP (MODV << (RED_N - 1 - j))
      ) u_red (
        .clk  (clk),
        .en   (adv),
        .din  (red[l][j]),
        .dout (red[l][j+1])
      );
    end

    // fold into [0, pi/2]; a full angle past pi/2 flips the sign of cos
    always_comb begin
      hv = 64'(red[l][RED_N]);
      if (l < 2) begin
        wrap = hv;
        fneg = 1'b0;
        fold = (hv > HALF_PI_Q30) ? PI_Q30 - hv : hv;
      end else begin
        wrap = (hv > PI_Q30) ? TWO_PI_Q30 - hv : hv;
        fneg = wrap > HALF_PI_Q30;
        fold = fneg ? PI_Q30 - wrap : wrap;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        theta[l]    <= 33'(fold);
        fold_neg[l] <= fneg;
      end
    end

    assign rot[l][0] = {CW'(CORDIC_GAIN_Q30), CW'(0), CW'(theta[l])};

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      hav_cordic_cell #(
        .STAGE  (i),
        .VECTOR (1'b0)
      ) u_rot (
        .clk  (clk),
        .en   (adv),
        .din  (rot[l][i]),
        .dout (rot[l][i+1])
      );
    end
  end

  // cos sign flags ride alongside the rotation chain
  logic [CORDIC_STAGES-1:0] neg_sr [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_sr[0] <= {neg_sr[0][CORDIC_STAGES-2:0], fold_neg[2]};
      neg_sr[1] <= {neg_sr[1][CORDIC_STAGES-2:0], fold_neg[3]};
    end
  end

  //--------------------------------------------------------------------------
  // Combine: a = hav_lat + cos1*cos2*hav_lon, clamped to [0, 1].
  //--------------------------------------------------------------------------
  logic [30:0]        sin_lat, sin_lon;
  logic [30:0]        cmag1, cmag2;
  logic signed [31:0] cos1, cos2;
  logic [30:0]        hav_lat, hav_lon, hav_lat_d;
  logic signed [31:0] cprod, term;
  logic signed [63:0] cmul, tmul;
  logic signed [32:0] asum;
  logic [30:0]        a_val, a_clamp;
  logic [30:0]        b_val;

  assign cmag1 = clamp_unit(rot[2][CORDIC_STAGES].x);
  assign cmag2 = clamp_unit(rot[3][CORDIC_STAGES].x);
  assign cmul  = 64'(cos1) * 64'(cos2);
  assign tmul  = 64'(cprod) * $signed(64'(hav_lon));
  assign asum  = 33'(term) + $signed(33'(hav_lat_d));
  assign a_clamp = clamp_unit(CW'(asum));

  always_ff @(posedge clk) begin
    if (adv) begin
      sin_lat   <= clamp_unit(rot[0][CORDIC_STAGES].y);
      sin_lon   <= clamp_unit(rot[1][CORDIC_STAGES].y);
      cos1      <= neg_sr[0][CORDIC_STAGES-1] ? -$signed(32'(cmag1)) : $signed(32'(cmag1));
      cos2      <= neg_sr[1][CORDIC_STAGES-1] ? -$signed(32'(cmag2)) : $signed(32'(cmag2));
      hav_lat   <= 31'((62'(sin_lat) * 62'(sin_lat)) >> 30);
      hav_lon   <= 31'((62'(sin_lon) * 62'(sin_lon)) >> 30);
      cprod     <= 32'(cmul >>> 30);
      term      <= 32'(tmul >>> 30);
      hav_lat_d <= hav_lat;
      a_val     <= a_clamp;
      b_val     <= 31'(ONE_Q30) - a_clamp;
    end
  end

  //--------------------------------------------------------------------------
  // sqrt(a) and sqrt(1-a): one root bit per cell, 31 cells per lane.
  //--------------------------------------------------------------------------
  sqrt_t sq [2][SQ_N+1];

  assign sq[0][0] = {SQ_W'(a_val) << 30, SQ_W'(0)};
  assign sq[1][0] = {SQ_W'(b_val) << 30, SQ_W'(0)};

  for (genvar l = 0; l < 2; l++) begin : g_sq
    for (genvar k = 0; k < SQ_N; k++) begin : g_bit
      hav_sqrt_cell #(
        .SHIFT (2 * (SQ_N - 1 - k))
      ) u_sq (
        .clk  (clk),
        .en   (adv),
        .din  (sq[l][k]),
        .dout (sq[l][k+1])
      );
    end
  end

  //--------------------------------------------------------------------------
  // Half central angle = atan2(sqrt(a), sqrt(1-a)) by vectoring CORDIC.
  //--------------------------------------------------------------------------
  cordic_t vec [CORDIC_STAGES+1];

  assign vec[0] = {CW'(sq[1][SQ_N].r), CW'(sq[0][SQ_N].r), CW'(0)};

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    hav_cordic_cell #(
      .STAGE  (i),
      .VECTOR (1'b1)
    ) u_vec (
      .clk  (clk),
      .en   (adv),
      .din  (vec[i]),
      .dout (vec[i+1])
    );
  end

  //--------------------------------------------------------------------------
  // Scale by radius: (R * half + 2^24) >> 25, saturate; output register.
  //--------------------------------------------------------------------------
  logic signed [CW-1:0] zfin;
  logic [30:0]          half;
  logic [53:0]          dprod;
  logic [30:0]          dist_rnd;

  assign zfin = vec[CORDIC_STAGES].z;
  assign dist_rnd = 31'((55'(dprod) + (55'(1) << 24)) >> 25);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (zfin < 0) begin
        half <= '0;
      end else if (zfin > $signed(CW'(HALF_PI_Q30))) begin
        half <= 31'(HALF_PI_Q30);
      end else begin
        half <= 31'(zfin);
      end
      dprod       <= 54'(radius) * 54'(half);
      distance_q4 <= (dist_rnd > 31'(DIST_MAX)) ? DIST_MAX : 30'(dist_rnd);
    end
  end

  //--------------------------------------------------------------------------
  // Checks
  //--------------------------------------------------------------------------
  // a beat taken while the pipeline is frozen must land in the skid
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !adv) |=> skid_full)
    else $error("accepted beat not captured in skid");

  // a parked beat leaves the skid as soon as the pipeline moves
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_full && adv) |=> (!skid_full && vld[0]))
    else $error("skid beat not moved into the pipeline");

endmodule

`default_nettype wire
